/* rtl/lpd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_pkg: shared types and constants
// Operation and status codes, default sizes and controller/datapath links.
// ----------------------------------------------------------------------------
package lpd_pkg;

	localparam int unsigned DEF_CAPACITY    = 16;
	localparam int unsigned DEF_HANDLE_BITS = 16;
	localparam int unsigned DEF_PIN_BITS    = 8;

	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_FETCH   = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISS     = 2'd1;
	localparam logic [1:0] ST_BLOCKED  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;  // register the incoming beat
		logic execute;  // perform the lookup result update and build the result
	} lpd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic busy;
	} lpd_sts_t;

endpackage
`default_nettype wire

/* rtl/lpd_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_req_if / lpd_rsp_if: valid-ready channels
// Request and response channels of the page directory.
// ----------------------------------------------------------------------------
interface lpd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] page_key;
	logic [15:0] page_handle;
	modport source (output valid, op, page_key, page_handle, input ready);
	modport sink   (input valid, op, page_key, page_handle, output ready);
endinterface

interface lpd_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] found_handle;
	logic        evicted;
	logic [15:0] evicted_handle;
	logic [31:0] evicted_page_num;
	modport source (output valid, status, found_handle, evicted, evicted_handle,
		evicted_page_num, input ready);
	modport sink   (input valid, status, found_handle, evicted, evicted_handle,
		evicted_page_num, output ready);
endinterface
`default_nettype wire

/* rtl/lru_page_directory_with_pins.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lru_page_directory_with_pins: fully associative LRU page directory
// Use: requests enter on req (op, page_key, page_handle); each request gives
// exactly one response beat on rsp. Insert may evict the least recent entry
// when full (blocked if pinned); fetch pins and promotes; release unpins.
// Each request is captured and matched, then the entries are updated and the
// response is registered on rsp. One request is in flight at a time: its match
// step, its update step and the delivery of its response beat all complete
// before the next request is accepted.
// The output register holds the response while the receiver stalls, and no
// new request is taken until that beat is delivered.
// Reset clears all valid bits and the entry count; the directory is empty
// and ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module lru_page_directory_with_pins
	import lpd_pkg::*;
#(
	parameter int unsigned CAPACITY    = DEF_CAPACITY,
	parameter int unsigned HANDLE_BITS = DEF_HANDLE_BITS,
	parameter int unsigned PIN_BITS    = DEF_PIN_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	lpd_req_if.sink  req,
	lpd_rsp_if.source rsp
);
	lpd_cmd_t cmd;
	lpd_sts_t sts;

	lpd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(req.ready),
		.out_full(sts.busy), .cmd(cmd)
	);

	lpd_dpath #(.CAPACITY(CAPACITY), .HANDLE_BITS(HANDLE_BITS), .PIN_BITS(PIN_BITS))
	u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .op(req.op), .page_key(req.page_key),
		.page_handle(req.page_handle), .out_ready(rsp.ready), .out_valid(rsp.valid),
		.status(rsp.status), .found_handle(rsp.found_handle), .evicted(rsp.evicted),
		.evicted_handle(rsp.evicted_handle), .evicted_page_num(rsp.evicted_page_num),
		.sts(sts)
	);

	// No request is taken while a response is pending.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready) else $error("accept while response pending");
	// Every accepted request yields a response after its update step.
	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> ##1 rsp.valid) else $error("missing response");
	// Eviction is only reported on an ok status.
	a_evict_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.evicted) |-> (rsp.status == ST_OK))
		else $error("eviction with bad status");
endmodule
`default_nettype wire

/* rtl/lpd_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_ctrl: request sequencer
// Two-step sequence per beat: capture and match, then update and respond.
// ----------------------------------------------------------------------------
module lpd_ctrl
	import lpd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic out_full,
	output lpd_cmd_t  cmd
);
	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_EXEC = 1'b1;

	logic [0:0] state_q;

	// A beat is taken when idle and the output register is free.
	assign in_ready    = (state_q == S_IDLE) && !out_full;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.execute = (state_q == S_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.capture) state_q <= S_EXEC;
				end
				S_EXEC: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/lpd_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_dpath: directory entries and result register
// Entry storage, parallel key match, LRU ranks, pin counts and output beat.
// ----------------------------------------------------------------------------
module lpd_dpath
	import lpd_pkg::*;
#(
	parameter int unsigned CAPACITY    = DEF_CAPACITY,
	parameter int unsigned HANDLE_BITS = DEF_HANDLE_BITS,
	parameter int unsigned PIN_BITS    = DEF_PIN_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  lpd_cmd_t         cmd,
	input  wire logic [1:0]  op,
	input  wire logic [31:0] page_key,
	input  wire logic [15:0] page_handle,
	input  wire logic        out_ready,
	output logic             out_valid,
	output logic [1:0]       status,
	output logic [15:0]      found_handle,
	output logic             evicted,
	output logic [15:0]      evicted_handle,
	output logic [31:0]      evicted_page_num,
	output lpd_sts_t         sts
);
	localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

	logic [CAPACITY-1:0]    valid_q;
	logic [31:0]            key_q    [CAPACITY];
	logic [HANDLE_BITS-1:0] handle_q [CAPACITY];
	logic [PIN_BITS-1:0]    pin_q    [CAPACITY];
	logic [IW-1:0]          rank_q   [CAPACITY];
	logic [CW-1:0]          count_q;

	logic [1:0]             op_s1;
	logic [31:0]            key_s1;
	logic [HANDLE_BITS-1:0] hdl_s1;
	logic [CAPACITY-1:0]    hit_s1;
	logic [CAPACITY-1:0]    lru_s1;
	logic [CAPACITY-1:0]    free_s1;

	logic [CAPACITY-1:0] hit_c, lru_c, free_c;
	logic                full_c;

	assign full_c = (count_q == CW'(CAPACITY));

	// Stage one: parallel key match, LRU and first free slot, one-hot each.
	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_c[i] = valid_q[i] && (key_q[i] == page_key);
			lru_c[i] = valid_q[i] && (rank_q[i] == IW'(CAPACITY - 1));
			free_c[i] = !valid_q[i] && !seen;
			if (!valid_q[i]) seen = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1   <= op;
			key_s1  <= page_key;
			hdl_s1  <= HANDLE_BITS'(page_handle);
			hit_s1  <= hit_c;
			lru_s1  <= full_c ? lru_c : '0;
			free_s1 <= free_c;
		end
	end

	// Stage two: select the matched and least recent entries.
	logic [HANDLE_BITS-1:0] hit_hdl, lru_hdl;
	logic [PIN_BITS-1:0]    lru_pin;
	logic [IW-1:0]          hit_rank;
	logic [31:0]            lru_key;
	logic                   any_hit, any_lru, blocked, do_evict, hit_after, add_new;
	logic [CAPACITY-1:0]    add_sel;

	always_comb begin
		hit_hdl = '0; lru_hdl = '0; lru_pin = '0;
		hit_rank = '0; lru_key = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit_s1[i]) begin
				hit_hdl |= handle_q[i]; hit_rank |= rank_q[i];
			end
			if (lru_s1[i]) begin
				lru_hdl |= handle_q[i]; lru_pin |= pin_q[i]; lru_key |= key_q[i];
			end
		end
		any_hit  = |hit_s1;
		any_lru  = |lru_s1;
		blocked  = any_lru && (lru_pin != '0);
		do_evict = any_lru && !blocked;
		// After eviction, a hit survives unless it was the evicted entry.
		hit_after = any_hit && !(do_evict && ((hit_s1 & lru_s1) != '0));
		add_new   = !blocked && !hit_after;
		// When an eviction frees a slot, that slot is the new one.
		add_sel = do_evict ? lru_s1 : free_s1;
	end

	// Entry updates and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (cmd.execute) begin
				out_valid <= 1'b1;
				if (op_s1 == OP_INSERT && add_new && !do_evict && (add_sel != '0))
					count_q <= count_q + CW'(1);
				// An eviction followed by a handle update leaves its slot free.
				if (op_s1 == OP_INSERT && do_evict && !add_new)
					count_q <= count_q - CW'(1);
				for (int i = 0; i < CAPACITY; i++) begin
					if (op_s1 == OP_INSERT && add_new && add_sel[i]) valid_q[i] <= 1'b1;
					if (op_s1 == OP_INSERT && do_evict && !add_new && lru_s1[i])
						valid_q[i] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status <= ST_OK; found_handle <= '0; evicted <= 1'b0;
			evicted_handle <= '0; evicted_page_num <= '0;
			case (op_s1)
				OP_INSERT: begin
					if (blocked) begin
						status <= ST_BLOCKED;
					end else begin
						evicted <= do_evict;
						if (do_evict) begin
							evicted_handle   <= 16'(lru_hdl);
							evicted_page_num <= lru_key;
						end
					end
					for (int i = 0; i < CAPACITY; i++) begin
						if (!blocked && hit_after && hit_s1[i]) handle_q[i] <= hdl_s1;
						if (add_new && add_sel[i]) begin
							key_q[i] <= key_s1; handle_q[i] <= hdl_s1;
							pin_q[i] <= '0; rank_q[i] <= '0;
						end else if (add_new && valid_q[i] && !(do_evict && lru_s1[i])) begin
							// The evicted entry held the last rank, so nothing closes
							// up behind it; the new entry pushes every other one down.
							rank_q[i] <= rank_q[i] + IW'(1);
						end
					end
				end
				OP_FETCH: begin
					if (!any_hit) begin
						status <= ST_MISS;
					end else begin
						found_handle <= 16'(hit_hdl);
						for (int i = 0; i < CAPACITY; i++) begin
							if (hit_s1[i]) begin
								rank_q[i] <= '0;
								if (pin_q[i] != PIN_MAX) pin_q[i] <= pin_q[i] + PIN_BITS'(1);
							end else if (valid_q[i] && rank_q[i] < hit_rank) begin
								rank_q[i] <= rank_q[i] + IW'(1);
							end
						end
					end
				end
				OP_RELEASE: begin
					if (!any_hit) begin
						status <= ST_MISS;
					end else begin
						for (int i = 0; i < CAPACITY; i++) begin
							if (hit_s1[i] && pin_q[i] != '0) pin_q[i] <= pin_q[i] - PIN_BITS'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign sts.busy = out_valid;
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the LRU page directory
// Drives insert, fetch, release and unused-op beats on the request channel,
// predicts each response with a behavioral copy of the directory, compares the
// response beats in order, under several phases of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
	import lpd_pkg::*;

	localparam int CAP = 16;
	localparam int PIN_MAX = 255;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] page_key;
		logic [15:0] page_handle;
	} page_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] found_handle;
		logic        evicted;
		logic [15:0] evicted_handle;
		logic [31:0] evicted_page_num;
	} page_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lpd_req_if req ();
	lpd_rsp_if rsp ();

	lru_page_directory_with_pins u_top (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	// Directory shadow state.
	logic        dir_valid [CAP];
	logic [31:0] dir_key   [CAP];
	logic [15:0] dir_handle[CAP];
	int          dir_pins  [CAP];
	int          dir_rank  [CAP];
	int          dir_count;

	page_req_t pending_reqs[$];
	page_rsp_t expected_rsps[$];
	int        error_count = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic int lookup_slot(input logic [31:0] key);
		for (int i = 0; i < CAP; i++)
			if (dir_valid[i] && dir_key[i] == key) return i;
		return -1;
	endfunction

	// Compute the response of one request and update the shadow directory.
	function automatic page_rsp_t predict_page_rsp(input page_req_t r);
		page_rsp_t o;
		int s, lru, rk, fr;
		o = '0;
		s = lookup_slot(r.page_key);
		if (r.op == OP_INSERT) begin
			if (dir_count >= CAP) begin
				lru = -1;
				for (int i = 0; i < CAP; i++)
					if (dir_valid[i] && (lru < 0 || dir_rank[i] > dir_rank[lru])) lru = i;
				if (dir_pins[lru] > 0) begin
					o.status = ST_BLOCKED;
					return o;
				end
				o.evicted = 1'b1;
				o.evicted_handle = dir_handle[lru];
				o.evicted_page_num = dir_key[lru];
				rk = dir_rank[lru];
				dir_valid[lru] = 1'b0;
				for (int i = 0; i < CAP; i++)
					if (dir_valid[i] && dir_rank[i] > rk) dir_rank[i]--;
				dir_count--;
				s = lookup_slot(r.page_key);
			end
			if (s >= 0) begin
				dir_handle[s] = r.page_handle;
			end else begin
				fr = -1;
				for (int i = CAP - 1; i >= 0; i--)
					if (!dir_valid[i]) fr = i;
				for (int i = 0; i < CAP; i++)
					if (dir_valid[i]) dir_rank[i]++;
				dir_valid[fr] = 1'b1;
				dir_key[fr] = r.page_key;
				dir_handle[fr] = r.page_handle;
				dir_pins[fr] = 0;
				dir_rank[fr] = 0;
				dir_count++;
			end
		end else if (r.op == OP_FETCH) begin
			if (s < 0) begin
				o.status = ST_MISS;
			end else begin
				o.found_handle = dir_handle[s];
				if (dir_pins[s] < PIN_MAX) dir_pins[s]++;
				rk = dir_rank[s];
				for (int i = 0; i < CAP; i++)
					if (dir_valid[i] && i != s && dir_rank[i] < rk) dir_rank[i]++;
				dir_rank[s] = 0;
			end
		end else if (r.op == OP_RELEASE) begin
			if (s < 0) o.status = ST_MISS;
			else if (dir_pins[s] > 0) dir_pins[s]--;
		end
		return o;
	endfunction

	// Driver: present the next pending beat, holding it until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.op <= '0;
			req.page_key <= '0;
			req.page_handle <= '0;
		end else if (!req.valid || req.ready) begin
			if (req.valid) expected_rsps.push_back(predict_page_rsp(
				page_req_t'{req.op, req.page_key, req.page_handle}));
			if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				page_req_t nx;
				nx = pending_reqs.pop_front();
				req.valid <= 1'b1;
				req.op <= nx.op;
				req.page_key <= nx.page_key;
				req.page_handle <= nx.page_handle;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each delivered response beat with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_rsps.size() == 0) begin
					report_mismatch("unexpected beat", 32'h0, 32'h0);
				end else begin
					page_rsp_t w;
					w = expected_rsps.pop_front();
					if (rsp.status !== w.status)
						report_mismatch("status", 32'(rsp.status), 32'(w.status));
					if (rsp.found_handle !== w.found_handle)
						report_mismatch("found_handle", 32'(rsp.found_handle),
							32'(w.found_handle));
					if (rsp.evicted !== w.evicted)
						report_mismatch("evicted", 32'(rsp.evicted), 32'(w.evicted));
					if (rsp.evicted_handle !== w.evicted_handle)
						report_mismatch("evicted_handle", 32'(rsp.evicted_handle),
							32'(w.evicted_handle));
					if (rsp.evicted_page_num !== w.evicted_page_num)
						report_mismatch("evicted_page_num", rsp.evicted_page_num,
							w.evicted_page_num);
				end
			end
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic queue_req(input logic [1:0] op, input logic [31:0] pg, input logic [15:0] h);
		pending_reqs.push_back(page_req_t'{op, pg, h});
	endtask

	// Random page numbers drawn mostly from a small pool so lookups hit.
	function automatic logic [31:0] pick_page();
		int k;
		k = $urandom_range(99);
		if (k < 85) return 32'hA500_0000 + $urandom_range(23);
		if (k < 92)
			return {1'($urandom_range(1)), 31'h0} | ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h0);
		return $urandom();
	endfunction

	task automatic wait_drain();
		while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int pct_send[4];
		int pct_recv[4];
		pct_send = '{0, 52, 0, 12};
		pct_recv = '{0, 0, 52, 12};
		for (int i = 0; i < CAP; i++) begin
			dir_valid[i] = 1'b0;
			dir_key[i] = '0;
			dir_handle[i] = '0;
			dir_pins[i] = 0;
			dir_rank[i] = 0;
		end
		dir_count = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: misses on empty, fill, eviction next to a pinned hit, saturation, unused op.
		queue_req(OP_FETCH, 32'h0, 16'h0);
		queue_req(OP_RELEASE, 32'hFFFF_FFFF, 16'hFFFF);
		queue_req(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
		for (int i = 0; i < 16; i++)
			queue_req(OP_INSERT, (i == 0) ? 32'h0 : (i == 1 ? 32'hFFFF_FFFF : 32'h100 + i),
				(i == 0) ? 16'h0 : 16'(16'hFFFF - i));
		queue_req(OP_FETCH, 32'h0, 16'h0);
		queue_req(OP_RELEASE, 32'h0, 16'h0);
		queue_req(OP_RELEASE, 32'h0, 16'h0);
		queue_req(OP_FETCH, 32'hFFFF_FFFF, 16'h0);
		queue_req(OP_INSERT, 32'hFFFF_FFFF, 16'h1234);
		queue_req(OP_INSERT, 32'h0, 16'h5555);
		for (int i = 0; i < 260; i++) queue_req(OP_FETCH, 32'h0, 16'h0);
		queue_req(OP_INSERT, 32'h200, 16'hAAAA);
		wait_drain();

		// Random phases with different idling.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = pct_send[ph];
			recv_stall_pct = pct_recv[ph];
			for (int n = 0; n < 400; n++) begin
				int k;
				k = $urandom_range(99);
				if (k < 40) queue_req(OP_INSERT, pick_page(), 16'($urandom()));
				else if (k < 70) queue_req(OP_FETCH, pick_page(), 16'($urandom()));
				else if (k < 97) queue_req(OP_RELEASE, pick_page(), 16'($urandom()));
				else queue_req(OP_UNUSED, $urandom(), 16'($urandom()));
			end
			wait_drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// Release every pool page repeatedly so full inserts can evict again.
		for (int r = 0; r < 3; r++)
			for (int p = 0; p < 24; p++) queue_req(OP_RELEASE, 32'hA500_0000 + p, 16'h0);
		for (int n = 0; n < 40; n++) queue_req(OP_INSERT, $urandom(), 16'($urandom()));
		wait_drain();

		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
